// ----- hw/rtl/f16m_pkg.sv -----
// ============================================================================
// f16m_pkg
// Shared types and constants for the FAT16 offset-to-sector mapper.
// ============================================================================
package f16m_pkg;

    localparam int unsigned MID_DEPTH_DEF = 4;
    localparam int unsigned OUT_DEPTH_DEF = 4;

    localparam logic [15:0] CHAIN_END_MIN    = 16'hfff7;
    localparam logic [15:0] NO_CLUSTER       = 16'hffff;
    localparam logic [15:0] FIRST_DATA_CLUS  = 16'd2;
    localparam logic [22:0] ROOT_DIR_SECTORS = 23'd32;

    localparam logic CMD_MAP   = 1'b0;
    localparam logic CMD_REPLY = 1'b1;

    localparam logic [1:0] CFG_SPC  = 2'd0;
    localparam logic [1:0] CFG_PART = 2'd1;
    localparam logic [1:0] CFG_ROOT = 2'd2;

    typedef enum logic [2:0] {
        KIND_CACHED    = 3'd0,
        KIND_FAT       = 3'd1,
        KIND_DATA      = 3'd2,
        KIND_FETCH_ERR = 3'd3,
        KIND_BAD_CHAIN = 3'd4
    } t_kind;

    typedef struct packed {
        logic [7:0]  spc;
        logic [31:0] part_first;
        logic [31:0] root_dir;
    } t_cfg;

    // work handed from the front to the back
    typedef struct packed {
        t_kind       kind;
        logic        root;
        logic [15:0] cluster;
        logic [31:0] offset;
    } t_job;

    typedef struct packed {
        t_job        job;
        logic [23:0] prod;
    } t_stage;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] addr;
        logic [8:0]  pos;
    } t_result;

    function automatic logic [7:0] spc_eff(input logic [7:0] spc);
        return (spc == 8'd0) ? 8'd1 : spc;
    endfunction

    function automatic logic bad_cluster(input logic [15:0] c);
        return (c < FIRST_DATA_CLUS) || (c >= CHAIN_END_MIN);
    endfunction

endpackage

// ----- hw/rtl/f16m_fifo.sv -----
// ============================================================================
// f16m_fifo
// Small register queue with occupancy count.
// ============================================================================
module f16m_fifo
    import f16m_pkg::*;
#(
    parameter int unsigned DEPTH = MID_DEPTH_DEF,
    parameter type t_data = t_job
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr,
    input  t_data                        i_data,
    input  logic                         i_rd,
    output t_data                        o_data,
    output logic                         o_empty,
    output logic                         o_full,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    t_data          r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic           wr_en;
    logic           rd_en;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- hw/rtl/f16m_front.sv -----
// ============================================================================
// f16m_front
// Classifies each input beat, keeps the cache and chain-walk state, and
// issues one job per result.
// ============================================================================
module f16m_front
    import f16m_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_accept,
    input  logic        i_cmd,
    input  logic [15:0] i_start_cluster,
    input  logic [31:0] i_byte_offset,
    input  logic [15:0] i_fat_entry,
    input  logic        i_fetch_failed,
    output logic        o_job_valid,
    output t_job        o_job
);

    logic [15:0] r_cached_cluster, n_cached_cluster;
    logic [22:0] r_cached_idx,     n_cached_idx;
    logic [15:0] r_walk_cluster,   n_walk_cluster;
    logic [31:0] r_remaining,      n_remaining;
    logic        r_walking,        n_walking;

    logic [16:0] clus_bytes;
    logic [17:0] two_clus_bytes;
    logic [22:0] idx;
    logic        start_bad;
    logic        hit;

    assign clus_bytes     = {spc_eff(i_cfg.spc), 9'd0};
    assign two_clus_bytes = {clus_bytes, 1'b0};
    assign idx            = i_byte_offset[31:9];
    assign start_bad      = (i_start_cluster != 16'd0) && bad_cluster(i_start_cluster);
    assign hit            = (i_start_cluster == r_cached_cluster) && (idx == r_cached_idx);

    always_comb begin
        n_cached_cluster = r_cached_cluster;
        n_cached_idx     = r_cached_idx;
        n_walk_cluster   = r_walk_cluster;
        n_remaining      = r_remaining;
        n_walking        = r_walking;
        o_job_valid      = 1'b0;
        o_job            = '0;
        o_job.kind       = KIND_CACHED;
        if (i_accept) begin
            if (i_cmd == CMD_MAP) begin
                o_job_valid = 1'b1;
                n_walking   = 1'b0;
                if (start_bad) begin
                    o_job.kind = KIND_BAD_CHAIN;
                end else if (hit) begin
                    o_job.kind = KIND_CACHED;
                end else begin
                    n_cached_cluster = i_start_cluster;
                    n_cached_idx     = idx;
                    o_job.cluster    = i_start_cluster;
                    o_job.offset     = i_byte_offset;
                    if (i_start_cluster == 16'd0) begin
                        o_job.kind = KIND_DATA;
                        o_job.root = 1'b1;
                    end else begin
                        n_walk_cluster = i_start_cluster;
                        n_remaining    = i_byte_offset;
                        if (i_byte_offset >= {15'd0, clus_bytes}) begin
                            o_job.kind = KIND_FAT;
                            n_walking  = 1'b1;
                        end else begin
                            o_job.kind = KIND_DATA;
                        end
                    end
                end
            end else if (r_walking) begin
                o_job_valid = 1'b1;
                if (i_fetch_failed || bad_cluster(i_fat_entry)) begin
                    o_job.kind       = i_fetch_failed ? KIND_FETCH_ERR : KIND_BAD_CHAIN;
                    n_walking        = 1'b0;
                    n_cached_cluster = NO_CLUSTER;
                end else begin
                    n_walk_cluster = i_fat_entry;
                    n_remaining    = r_remaining - {15'd0, clus_bytes};
                    o_job.cluster  = i_fat_entry;
                    o_job.offset   = n_remaining;
                    // remaining - cb >= cb, checked without waiting on the subtract;
                    // below cb the subtract wraps to a huge offset
                    if ((r_remaining >= {14'd0, two_clus_bytes}) ||
                        (r_remaining < {15'd0, clus_bytes})) begin
                        o_job.kind = KIND_FAT;
                    end else begin
                        o_job.kind = KIND_DATA;
                        n_walking  = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cached_cluster <= NO_CLUSTER;
            r_cached_idx     <= '0;
            r_walk_cluster   <= '0;
            r_remaining      <= '0;
            r_walking        <= 1'b0;
        end else begin
            r_cached_cluster <= n_cached_cluster;
            r_cached_idx     <= n_cached_idx;
            r_walk_cluster   <= n_walk_cluster;
            r_remaining      <= n_remaining;
            r_walking        <= n_walking;
        end
    end

endmodule

// ----- hw/rtl/f16m_back.sv -----
// ============================================================================
// f16m_back
// Turns jobs into card addresses: multiply stage, then address adders that
// feed the result queue.
// ============================================================================
module f16m_back
    import f16m_pkg::*;
#(
    parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_job_avail,
    input  t_job    i_job,
    output logic    o_job_take,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    localparam int unsigned CW = $clog2(OUT_DEPTH + 1);

    t_stage         r_s1;
    logic           r_s1_v;
    logic [CW-1:0]  out_count;
    logic           out_full;
    logic [15:0]    clus_m2;
    logic [23:0]    prod;
    logic [22:0]    fat_base;
    logic [31:0]    fat_pos;
    logic [22:0]    sect;
    t_result        res;

    // credit: queued results plus the one in flight never exceed the queue
    assign o_job_take = i_job_avail &&
        ({1'b0, out_count} + {{CW{1'b0}}, r_s1_v} < (CW + 1)'(OUT_DEPTH));

    assign clus_m2 = i_job.cluster - FIRST_DATA_CLUS;
    assign prod    = {8'd0, clus_m2} * {16'd0, spc_eff(i_cfg.spc)};

    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_s1.job  <= i_job;
            r_s1.prod <= prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= o_job_take;
        end
    end

    assign fat_base = i_cfg.part_first[22:0] + 23'd1;
    assign fat_pos  = {fat_base, 9'd0} + {15'd0, r_s1.job.cluster, 1'b0};

    always_comb begin
        if (r_s1.job.root) begin
            sect = i_cfg.root_dir[22:0] + r_s1.job.offset[31:9];
        end else begin
            sect = i_cfg.root_dir[22:0] + ROOT_DIR_SECTORS + r_s1.prod[22:0]
                 + r_s1.job.offset[31:9];
        end
    end

    always_comb begin
        res      = '0;
        res.kind = r_s1.job.kind;
        case (r_s1.job.kind)
            KIND_FAT: begin
                res.addr = {fat_pos[31:9], 9'd0};
                res.pos  = fat_pos[8:0];
            end
            KIND_DATA: begin
                res.addr = {sect, 9'd0};
            end
            default: begin
                res.addr = '0;
            end
        endcase
    end

    f16m_fifo #(
        .DEPTH  (OUT_DEPTH),
        .t_data (t_result)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (r_s1_v),
        .i_data  (res),
        .i_rd    (i_pop),
        .o_data  (o_result),
        .o_empty (o_empty),
        .o_full  (out_full),
        .o_count (out_count)
    );

    // credit check keeps the result queue from overflowing
    logic unused_full;
    assign unused_full = out_full;

endmodule

// ----- hw/rtl/fat16_offset_to_sector_mapper.sv -----
// ============================================================================
// fat16_offset_to_sector_mapper
// FAT16 start cluster + byte offset to card sector address, one chain step
// per beat.
// ============================================================================
// Takes one input beat per cycle whenever full is low. The front updates the
// cache and chain-walk state in the cycle a beat is accepted and queues a
// job; the back multiplies (cluster - 2) by the cluster size in one stage and
// forms the card address in the next, writing a result queue. Results drain one per
// cycle. A reply beat that arrives while no walk is running gives no result.
// Configuration writes take effect on the next cycle and belong to idle time.
// ============================================================================
module fat16_offset_to_sector_mapper
    import f16m_pkg::*;
#(
    parameter int unsigned MID_DEPTH = MID_DEPTH_DEF,
    parameter int unsigned OUT_DEPTH = OUT_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic        i_cmd,
    input  logic [15:0] i_start_cluster,
    input  logic [31:0] i_byte_offset,
    input  logic [15:0] i_fat_entry,
    input  logic        i_fetch_failed,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_kind,
    output logic [31:0] o_card_address,
    output logic [8:0]  o_entry_position
);

    localparam int unsigned MCW = $clog2(MID_DEPTH + 1);

    t_cfg           r_cfg;
    logic           accept;
    logic           job_valid;
    t_job           job;
    t_job           mid_head;
    logic           mid_empty;
    logic           mid_take;
    logic [MCW-1:0] mid_count;
    t_result        result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.spc        <= 8'd1;
            r_cfg.part_first <= '0;
            r_cfg.root_dir   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SPC:  r_cfg.spc        <= i_cfg_data[7:0];
                CFG_PART: r_cfg.part_first <= i_cfg_data;
                CFG_ROOT: r_cfg.root_dir   <= i_cfg_data;
                default:  r_cfg            <= r_cfg;
            endcase
        end
    end

    assign accept = push && !full;

    f16m_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_accept        (accept),
        .i_cmd           (i_cmd),
        .i_start_cluster (i_start_cluster),
        .i_byte_offset   (i_byte_offset),
        .i_fat_entry     (i_fat_entry),
        .i_fetch_failed  (i_fetch_failed),
        .o_job_valid     (job_valid),
        .o_job           (job)
    );

    f16m_fifo #(
        .DEPTH  (MID_DEPTH),
        .t_data (t_job)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (job_valid),
        .i_data  (job),
        .i_rd    (mid_take),
        .o_data  (mid_head),
        .o_empty (mid_empty),
        .o_full  (full),
        .o_count (mid_count)
    );

    f16m_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_avail (!mid_empty),
        .i_job       (mid_head),
        .o_job_take  (mid_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (result)
    );

    assign o_kind           = result.kind;
    assign o_card_address   = result.addr;
    assign o_entry_position = result.pos;

    // occupancy of the job queue is only needed inside the queue itself
    logic unused_mid_count;
    assign unused_mid_count = ^mid_count;

endmodule
